[hdl/lnds_pkg.sv]
// Shared constants, types and control structs of the non-decreasing subsequence block.
`timescale 1ns / 1ps
`default_nettype none
package lnds_pkg;

	localparam int VALUE_BITS  = 10;
	localparam int LENGTH_BITS = 16;
	localparam int POS_BITS    = VALUE_BITS + 1;
	localparam int NUM_VALUES  = 1 << VALUE_BITS;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY,
		ST_LEN,
		ST_URD,
		ST_UWR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CMP_QUERY,
		CMP_BEST,
		CMP_UPDATE
	} cmp_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     accept;
		logic     query;
		logic     len_load;
		logic     upd_rd;
		logic     upd_wr;
		logic     emit;
		logic     clear;
		logic     walk_up;
		cmp_sel_t cmp_sel;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic q_end;
		logic u_end;
		logic clr_end;
		logic out_free;
		logic last;
	} stat_t;

endpackage
`default_nettype wire

[hdl/lnds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lnds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/lnds_walk.sv]
// Fenwick index stepper: adds or subtracts the lowest set bit of the position.
`timescale 1ns / 1ps
`default_nettype none
module lnds_walk (
	input  wire logic [lnds_pkg::POS_BITS-1:0] pos,
	input  wire logic                          up,
	output logic      [lnds_pkg::POS_BITS:0]   next_pos
);

	logic [lnds_pkg::POS_BITS:0] pos_ext;
	logic [lnds_pkg::POS_BITS:0] low;

	always_comb begin
		pos_ext  = {1'b0, pos};
		low      = pos_ext & (~pos_ext + 1'b1);
		next_pos = up ? (pos_ext + low) : (pos_ext - low);
	end

endmodule
`default_nettype wire

[hdl/lnds_ctrl.sv]
// Sequencer for the clear sweep, query walk and update walk.
`timescale 1ns / 1ps
`default_nettype none
module lnds_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lnds_pkg::stat_t stat,
	output lnds_pkg::ctrl_t      ctrl
);

	lnds_pkg::state_t state_q;
	lnds_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lnds_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lnds_pkg::ST_CLEAR: begin
				if (stat.clr_end) state_d = lnds_pkg::ST_IDLE;
			end
			lnds_pkg::ST_IDLE: begin
				if (stat.in_valid) state_d = lnds_pkg::ST_QUERY;
			end
			lnds_pkg::ST_QUERY: begin
				if (stat.q_end) state_d = lnds_pkg::ST_LEN;
			end
			lnds_pkg::ST_LEN: begin
				state_d = lnds_pkg::ST_URD;
			end
			lnds_pkg::ST_URD: begin
				state_d = lnds_pkg::ST_UWR;
			end
			lnds_pkg::ST_UWR: begin
				state_d = stat.u_end ? lnds_pkg::ST_DONE : lnds_pkg::ST_URD;
			end
			lnds_pkg::ST_DONE: begin
				if (stat.out_free) begin
					state_d = stat.last ? lnds_pkg::ST_CLEAR : lnds_pkg::ST_IDLE;
				end
			end
			default: state_d = lnds_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.cmp_sel = lnds_pkg::CMP_QUERY;
		unique case (state_q)
			lnds_pkg::ST_CLEAR: ctrl.clear = 1'b1;
			lnds_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.accept   = stat.in_valid;
			end
			lnds_pkg::ST_QUERY: ctrl.query = 1'b1;
			lnds_pkg::ST_LEN:   ctrl.len_load = 1'b1;
			lnds_pkg::ST_URD: begin
				ctrl.upd_rd  = 1'b1;
				ctrl.cmp_sel = lnds_pkg::CMP_BEST;
			end
			lnds_pkg::ST_UWR: begin
				ctrl.upd_wr  = 1'b1;
				ctrl.walk_up = 1'b1;
				ctrl.cmp_sel = lnds_pkg::CMP_UPDATE;
			end
			lnds_pkg::ST_DONE: ctrl.emit = stat.out_free;
			default: ctrl.clear = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

[hdl/longest_nondecreasing_subseq_length.sv]
// Top level: longest non-decreasing subsequence length over a prefix-max Fenwick tree.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  input   | in_valid, in_ready, sample_value, last_item | in
//  output  | out_valid, out_ready, length_here,        | out
//          | best_length, sequence_done                |
//
// One beat runs the query walk, then the update walk, before in_ready rises again;
// the tree memory's single read port sets the pace, one node per read.
// The update walk reads each node in URD, then compares and writes it in UWR.
// After reset and after each last beat a sweep zeroes all 1024 tree entries;
// in_ready stays low during it. A stalled output holds the next result in DONE.
`timescale 1ns / 1ps
`default_nettype none
module longest_nondecreasing_subseq_length (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [lnds_pkg::VALUE_BITS-1:0]  sample_value,
	input  wire logic                             last_item,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [lnds_pkg::LENGTH_BITS-1:0] length_here,
	output logic      [lnds_pkg::LENGTH_BITS-1:0] best_length,
	output logic                                  sequence_done
);

	lnds_pkg::ctrl_t ctrl;
	lnds_pkg::stat_t stat;

	logic [lnds_pkg::POS_BITS-1:0]    start_q;
	logic [lnds_pkg::POS_BITS-1:0]    pos_q;
	logic [lnds_pkg::POS_BITS:0]      next_pos;
	logic [lnds_pkg::LENGTH_BITS-1:0] best_q;
	logic [lnds_pkg::LENGTH_BITS-1:0] len_q;
	logic [lnds_pkg::LENGTH_BITS-1:0] running_q;
	logic                             last_q;
	logic                             rd_pend_q;
	logic [lnds_pkg::VALUE_BITS-1:0]  clr_q;
	logic                             out_valid_q;
	logic [lnds_pkg::LENGTH_BITS-1:0] length_here_q;
	logic [lnds_pkg::LENGTH_BITS-1:0] best_length_q;
	logic                             done_q;

	logic [lnds_pkg::LENGTH_BITS-1:0] rdata;
	logic [lnds_pkg::VALUE_BITS-1:0]  node_addr;
	logic                             we;
	logic [lnds_pkg::VALUE_BITS-1:0]  waddr;
	logic [lnds_pkg::LENGTH_BITS-1:0] wdata;
	logic [lnds_pkg::LENGTH_BITS-1:0] cmp_x;
	logic [lnds_pkg::LENGTH_BITS-1:0] cmp_y;
	logic                             cmp_lt;
	logic                             q_issue;

	lnds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	lnds_walk u_walk (
		.pos      (pos_q),
		.up       (ctrl.walk_up),
		.next_pos (next_pos)
	);

	lnds_ram #(
		.WIDTH (lnds_pkg::LENGTH_BITS),
		.DEPTH (lnds_pkg::NUM_VALUES)
	) u_tree (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (node_addr),
		.rdata (rdata)
	);

	// tree position p lives at address p - 1
	assign node_addr = lnds_pkg::VALUE_BITS'(pos_q - 1'b1);
	assign q_issue   = ctrl.query && (pos_q != '0);

	// shared comparator
	always_comb begin
		unique case (ctrl.cmp_sel)
			lnds_pkg::CMP_QUERY: begin
				cmp_x = best_q;
				cmp_y = rdata;
			end
			lnds_pkg::CMP_BEST: begin
				cmp_x = running_q;
				cmp_y = len_q;
			end
			lnds_pkg::CMP_UPDATE: begin
				cmp_x = rdata;
				cmp_y = len_q;
			end
			default: begin
				cmp_x = best_q;
				cmp_y = rdata;
			end
		endcase
		cmp_lt = cmp_x < cmp_y;
	end

	always_comb begin
		if (ctrl.clear) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = ctrl.upd_wr && cmp_lt;
			waddr = node_addr;
			wdata = len_q;
		end
	end

	always_comb begin
		stat.in_valid = in_valid;
		stat.q_end    = (pos_q == '0) && !rd_pend_q;
		stat.u_end    = next_pos > (lnds_pkg::POS_BITS + 1)'(lnds_pkg::NUM_VALUES);
		stat.clr_end  = &clr_q;
		stat.out_free = !out_valid_q || out_ready;
		stat.last     = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clear) clr_q <= clr_q + 1'b1;
			rd_pend_q <= q_issue;
			if (ctrl.upd_rd && cmp_lt) running_q <= len_q;
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
				if (last_q) running_q <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			start_q <= {1'b0, sample_value} + 1'b1;
			pos_q   <= {1'b0, sample_value} + 1'b1;
			best_q  <= '0;
			last_q  <= last_item;
		end
		if (q_issue) pos_q <= lnds_pkg::POS_BITS'(next_pos);
		if (ctrl.query && rd_pend_q && cmp_lt) best_q <= rdata;
		if (ctrl.len_load) begin
			len_q <= (best_q == lnds_pkg::LEN_MAX) ? lnds_pkg::LEN_MAX : best_q + 1'b1;
			pos_q <= start_q;
		end
		if (ctrl.upd_wr && !stat.u_end) pos_q <= lnds_pkg::POS_BITS'(next_pos);
		if (ctrl.emit) begin
			length_here_q <= len_q;
			best_length_q <= running_q;
			done_q        <= last_q;
		end
	end

	assign in_ready      = ctrl.in_ready;
	assign out_valid     = out_valid_q;
	assign length_here   = length_here_q;
	assign best_length   = best_length_q;
	assign sequence_done = done_q;

endmodule
`default_nettype wire

[hdl/lnds_checker.sv]
// Port-level checker for the non-decreasing subsequence block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module lnds_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [lnds_pkg::LENGTH_BITS-1:0] length_here,
	input wire logic [lnds_pkg::LENGTH_BITS-1:0] best_length,
	input wire logic                             sequence_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(length_here)
			&& $stable(best_length) && $stable(sequence_done))
		else $error("result changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length_here != '0)
		else $error("chain length of zero");

	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length >= length_here)
		else $error("best length below chain length");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after an accepted beat");

endmodule

bind longest_nondecreasing_subseq_length lnds_checker u_lnds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.length_here   (length_here),
	.best_length   (best_length),
	.sequence_done (sequence_done)
);
`default_nettype wire
